### hdl/qpm_pkg.sv
// Shared types and constants for the QPSK pulse-shaping modulator.
// Beat payloads, controller/datapath command and status, symbol and sign codes.
// No dependencies.
`timescale 1ns / 1ps

package qpm_pkg;

  localparam int SAMPLE_W   = 20;
  localparam int SAMPLE_MAX = 524287;
  localparam int SAMPLE_MIN = -524288;

  // Item kind
  localparam logic CMD_SYMBOL = 1'b0;
  localparam logic CMD_COEF   = 1'b1;

  // Symbol codes
  localparam logic [1:0] SYM_I_POS = 2'h0;
  localparam logic [1:0] SYM_Q_POS = 2'h1;
  localparam logic [1:0] SYM_Q_NEG = 2'h2;
  localparam logic [1:0] SYM_I_NEG = 2'h3;

  typedef logic signed [1:0] sign_t;

  localparam sign_t SIGN_ZERO = 2'sb00;
  localparam sign_t SIGN_POS  = 2'sb01;
  localparam sign_t SIGN_NEG  = 2'sb11;

  typedef struct packed {
    logic               cmd;
    logic [1:0]         symbol;
    logic [7:0]         coef_index;
    logic signed [15:0] coef_value;
  } qpm_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [4:0]                 sample_index;
    logic                       last;
  } qpm_out_t;

  typedef struct packed {
    logic coef_wr;
    logic hist_shift;
    logic tap_read;
    logic emit;
  } qpm_cmd_t;

  typedef struct packed {
    logic tap_last;
    logic sample_last;
    logic out_free;
  } qpm_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_EMIT
  } qpm_state_t;

  function automatic sign_t sym_i(logic [1:0] sym);
    sign_t s;
    unique case (sym)
      SYM_I_POS: s = SIGN_POS;
      SYM_I_NEG: s = SIGN_NEG;
      default:   s = SIGN_ZERO;
    endcase
    return s;
  endfunction

  function automatic sign_t sym_q(logic [1:0] sym);
    sign_t s;
    unique case (sym)
      SYM_Q_POS: s = SIGN_POS;
      SYM_Q_NEG: s = SIGN_NEG;
      default:   s = SIGN_ZERO;
    endcase
    return s;
  endfunction

endpackage

### hdl/qpsk_pulse_shaping_modulator.sv
// Top level of the QPSK pulse-shaping modulator with fs/4 upconversion.
// Joins qpm_ctrl and qpm_datapath; depends on qpm_pkg.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid / in_stall / in_data): each beat is either a
//   coefficient write (cmd = 1) or a symbol (cmd = 0). Load the whole pulse
//   table with coefficient writes before sending the first symbol. A write
//   at an index at or beyond SAMPLES_PER_SYM*SPAN_SYMBOLS is dropped.
//   Output channel (out_valid / out_stall / out_data): each symbol yields
//   SAMPLES_PER_SYM beats, sample_index counting up from 0, last set on the
//   final one. Coefficient writes yield no beat.
// Sequencing
//   A coefficient write leaves the sequencer idle. For each sample of a
//   symbol the sequencer reads every tap through the single memory read
//   port, lets the last read drain into the accumulator and then loads
//   the output register; after the final sample it goes back to idle to
//   take the next beat. in_stall is high while a symbol is in work; the
//   last sample may still sit in the output register while the next beat
//   is taken.
// Reset and backpressure
//   Reset clears the symbol history to zero and empties the output register;
//   the coefficient memory keeps whatever it holds. While out_stall is high
//   the output beat holds and the sequencer waits before the next sample.

module qpsk_pulse_shaping_modulator
  import qpm_pkg::*;
#(
  parameter int SAMPLES_PER_SYM = 24,
  parameter int SPAN_SYMBOLS    = 10,
  parameter int COEF_WIDTH      = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  qpm_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output qpm_out_t out_data
);

  qpm_cmd_t  dp_cmd;
  qpm_stat_t dp_stat;

  // Sequencer: owns the handshake on the input side
  qpm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_data.cmd),
    .in_stall (in_stall),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  // Datapath: history, coefficient memory, accumulator and output register
  qpm_datapath #(
    .SAMPLES_PER_SYM (SAMPLES_PER_SYM),
    .SPAN_SYMBOLS    (SPAN_SYMBOLS),
    .COEF_WIDTH      (COEF_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (dp_cmd),
    .stat      (dp_stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### hdl/qpm_ctrl.sv
// Sequencer for the QPSK modulator: accepts beats and steps the datapath
// through tap reads and sample emission. Depends on qpm_pkg.
`timescale 1ns / 1ps

module qpm_ctrl
  import qpm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_cmd,
  output logic      in_stall,
  input  qpm_stat_t stat,
  output qpm_cmd_t  cmd
);

  qpm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_COEF) begin
            cmd.coef_wr = 1'b1;
          end else begin
            cmd.hist_shift = 1'b1;
            state_nxt      = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd.tap_read = 1'b1;
        if (stat.tap_last) begin
          state_nxt = ST_WAIT;
        end
      end
      // last coefficient lands in the accumulator
      ST_WAIT: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = stat.sample_last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/qpm_datapath.sv
// Datapath of the QPSK modulator: symbol history, coefficient memory,
// tap accumulator, carrier mix, saturation and output register. Depends on qpm_pkg.
`timescale 1ns / 1ps

module qpm_datapath
  import qpm_pkg::*;
#(
  parameter int SAMPLES_PER_SYM = 24,
  parameter int SPAN_SYMBOLS    = 10,
  parameter int COEF_WIDTH      = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  qpm_in_t   in_data,
  input  qpm_cmd_t  cmd,
  output qpm_stat_t stat,
  output logic      out_valid,
  input  logic      out_stall,
  output qpm_out_t  out_data
);

  localparam int TABLE_SIZE = SAMPLES_PER_SYM * SPAN_SYMBOLS;
  localparam int AW   = $clog2(TABLE_SIZE);
  localparam int KW   = $clog2(SAMPLES_PER_SYM);
  localparam int TW   = (SPAN_SYMBOLS > 1) ? $clog2(SPAN_SYMBOLS) : 1;
  localparam int ACCW = COEF_WIDTH + $clog2(SPAN_SYMBOLS) + 1;

  sign_t                  hist_i_r [SPAN_SYMBOLS];
  sign_t                  hist_q_r [SPAN_SYMBOLS];
  logic signed [COEF_WIDTH-1:0] coef_mem [TABLE_SIZE];

  logic signed [COEF_WIDTH-1:0] rd_coef_r;
  sign_t                        sign_r, sign_nxt;
  logic                         rd_vld_r;
  logic signed [ACCW-1:0]       acc_r, term;
  logic [TW-1:0]                t_r;
  logic [KW-1:0]                k_r;
  logic [AW-1:0]                addr_r;
  logic                         out_valid_r;
  qpm_out_t                     out_data_r;

  logic                         wr_ok;
  logic signed [23:0]           wr_ext;
  sign_t                        h_sel;
  logic                         mix_neg;
  logic signed [31:0]           acc_w;
  logic signed [SAMPLE_W-1:0]   sample_sat;

  assign wr_ok  = 32'(in_data.coef_index) < TABLE_SIZE;
  assign wr_ext = 24'(in_data.coef_value);

  // Carrier at fs/4: +I, -Q, -I, +Q; fold the negation into the tap sign
  assign mix_neg  = k_r[0] ^ k_r[1];
  assign h_sel    = k_r[0] ? hist_q_r[t_r] : hist_i_r[t_r];
  assign sign_nxt = mix_neg ? -h_sel : h_sel;

  always_comb begin
    case (sign_r)
      SIGN_POS: term = ACCW'(rd_coef_r);
      SIGN_NEG: term = -ACCW'(rd_coef_r);
      default:  term = '0;
    endcase
  end

  always_comb begin
    acc_w = 32'(acc_r);
    if (acc_w > SAMPLE_MAX) begin
      sample_sat = SAMPLE_W'(SAMPLE_MAX);
    end else if (acc_w < SAMPLE_MIN) begin
      sample_sat = SAMPLE_W'(SAMPLE_MIN);
    end else begin
      sample_sat = acc_w[SAMPLE_W-1:0];
    end
  end

  assign stat.tap_last    = (t_r == TW'(SPAN_SYMBOLS - 1));
  assign stat.sample_last = (k_r == KW'(SAMPLES_PER_SYM - 1));
  assign stat.out_free    = !out_valid_r || !out_stall;

  // Coefficient memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.coef_wr && wr_ok) begin
      coef_mem[AW'(in_data.coef_index)] <= wr_ext[COEF_WIDTH-1:0];
    end
    if (cmd.tap_read) begin
      rd_coef_r <= coef_mem[addr_r];
      sign_r    <= sign_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SPAN_SYMBOLS; i++) begin
        hist_i_r[i] <= SIGN_ZERO;
        hist_q_r[i] <= SIGN_ZERO;
      end
    end else if (cmd.hist_shift) begin
      for (int i = SPAN_SYMBOLS - 1; i > 0; i--) begin
        hist_i_r[i] <= hist_i_r[i-1];
        hist_q_r[i] <= hist_q_r[i-1];
      end
      hist_i_r[0] <= sym_i(in_data.symbol);
      hist_q_r[0] <= sym_q(in_data.symbol);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      acc_r    <= '0;
      t_r      <= '0;
      k_r      <= '0;
      addr_r   <= '0;
    end else begin
      rd_vld_r <= cmd.tap_read;
      if (cmd.hist_shift || cmd.emit) begin
        acc_r <= '0;
      end else if (rd_vld_r) begin
        acc_r <= acc_r + term;
      end
      if (cmd.hist_shift) begin
        t_r    <= '0;
        k_r    <= '0;
        addr_r <= '0;
      end else if (cmd.emit) begin
        t_r    <= '0;
        k_r    <= k_r + 1'b1;
        addr_r <= AW'(KW'(k_r + 1'b1));
      end else if (cmd.tap_read) begin
        t_r    <= t_r + 1'b1;
        addr_r <= addr_r + AW'(SAMPLES_PER_SYM);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.sample       <= sample_sat;
      out_data_r.sample_index <= 5'(k_r);
      out_data_r.last         <= stat.sample_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### hdl/qpm_checker.sv
// Port-level checks for the QPSK modulator, bound to the top level.
// Depends on qpm_pkg and qpsk_pulse_shaping_modulator.
`timescale 1ns / 1ps

module qpm_checker
  import qpm_pkg::*;
#(
  parameter int SAMPLES_PER_SYM = 24
) (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input qpm_in_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input qpm_out_t out_data
);

  // A symbol beat starts work, so the next beat must wait
  a_sym_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.cmd == CMD_SYMBOL) |=> in_stall)
    else $error("symbol beat did not raise in_stall");

  // Mid-symbol samples only appear while the block is busy
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> in_stall)
    else $error("non-final sample while input side ready");

  // The final sample of a symbol carries the last index
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |-> out_data.sample_index == 5'(SAMPLES_PER_SYM - 1))
    else $error("last flag on wrong sample index");

  // Stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output beat changed under stall");

endmodule

bind qpsk_pulse_shaping_modulator qpm_checker #(
  .SAMPLES_PER_SYM (SAMPLES_PER_SYM)
) u_qpm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### verif/qpsk_pulse_shaping_modulator_tb.sv
// Self-checking testbench for qpsk_pulse_shaping_modulator: pulse-table loads, symbol beats,
// random idling on both channels; every output beat is checked against an in-bench predictor.
// Depends on qpm_pkg and the qpsk_pulse_shaping_modulator RTL.
`timescale 1ns / 1ps

module qpsk_pulse_shaping_modulator_tb;
  import qpm_pkg::*;

  localparam int SPS         = 24;          // samples per symbol
  localparam int TAPS        = 10;          // symbols spanned by the pulse
  localparam int TABLE_N     = SPS * TAPS;  // pulse table entries
  localparam int IDLE_PCT    = 28;          // idle/stall odds per cycle, in percent
  localparam int RAND_ITEMS  = 360;
  localparam int LIMIT       = 1000000;     // cycles before the run is declared hung
  localparam int TAIL_CYCLES = 40;

  // Sender runs without random idling over this range of accepted beats; a drain marker still holds it.
  localparam int SEND_STEADY_LO = 560;
  localparam int SEND_STEADY_HI = 680;
  // Receiver never stalls over this range of received samples.
  localparam int RECV_STEADY_LO = 3000;
  localparam int RECV_STEADY_HI = 4200;
  // Receiver holds off once, long enough to back the block up into its input.
  localparam int HOLD_AT     = 1200;
  localparam int HOLD_CYCLES = 800;

  // Carrier phase, k mod 4, at a quarter of the sample rate.
  localparam logic [1:0] PH_PLUS_I  = 2'd0;
  localparam logic [1:0] PH_MINUS_Q = 2'd1;
  localparam logic [1:0] PH_MINUS_I = 2'd2;
  localparam logic [1:0] PH_PLUS_Q  = 2'd3;

  localparam logic signed [15:0] COEF_MIN = -16'sd32768;
  localparam logic signed [15:0] COEF_MAX = 16'sd32767;

  // A queued input beat; drain asks the sender to wait until all samples are back.
  typedef struct packed {
    logic    drain;
    qpm_in_t beat;
  } pending_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  qpm_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  qpm_out_t out_data;

  pending_t pending_items [$];
  qpm_out_t expected_samples [$];

  // Predictor state: sign history (newest at tap 0) and the pulse table.
  int               hist_i [TAPS];
  int               hist_q [TAPS];
  logic signed [15:0] pulse_table [TABLE_N];

  logic in_took      = 1'b0;  // input beat accepted at the last rising edge
  int   beats_sent   = 0;
  int   samples_seen = 0;
  int   mismatches   = 0;
  int   cycle_count  = 0;
  logic held_off     = 1'b0;
  int   hold_left    = 0;

  qpsk_pulse_shaping_modulator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Update the predictor with one accepted beat. A coefficient write stores
  // (or drops, when the address lies past the table) and yields nothing; a
  // symbol shifts the history and queues one full period of samples.
  task automatic predict_samples(input qpm_in_t b);
    int       acc;
    int       idx;
    qpm_out_t s;
    if (b.cmd == CMD_COEF) begin
      idx = int'(b.coef_index);
      if (idx < TABLE_N) pulse_table[idx] = b.coef_value;
      return;
    end
    for (int t = TAPS - 1; t > 0; t--) begin
      hist_i[t] = hist_i[t-1];
      hist_q[t] = hist_q[t-1];
    end
    case (b.symbol)
      SYM_I_POS: begin hist_i[0] = 1;  hist_q[0] = 0;  end
      SYM_Q_POS: begin hist_i[0] = 0;  hist_q[0] = 1;  end
      SYM_Q_NEG: begin hist_i[0] = 0;  hist_q[0] = -1; end
      default:   begin hist_i[0] = -1; hist_q[0] = 0;  end
    endcase
    for (int k = 0; k < SPS; k++) begin
      acc = 0;
      for (int t = 0; t < TAPS; t++) begin
        // Even phases take the I rail, odd phases the Q rail.
        if (k[0] == 1'b0) acc += hist_i[t] * int'(pulse_table[t*SPS + k]);
        else              acc += hist_q[t] * int'(pulse_table[t*SPS + k]);
      end
      // Mix with the quarter-rate carrier: +I, -Q, -I, +Q.
      case (k[1:0])
        PH_MINUS_Q, PH_MINUS_I: acc = -acc;
        default: ;
      endcase
      if (acc > SAMPLE_MAX) acc = SAMPLE_MAX;
      if (acc < SAMPLE_MIN) acc = SAMPLE_MIN;
      s.sample       = acc[SAMPLE_W-1:0];
      s.sample_index = k[4:0];
      s.last         = (k == SPS - 1);
      expected_samples.push_back(s);
    end
  endtask

  // Unused fields of each beat carry random noise; the block must ignore them.
  task automatic queue_coef(input int idx, input logic signed [15:0] val, input logic drain);
    pending_t p;
    p.drain           = drain;
    p.beat.cmd        = CMD_COEF;
    p.beat.symbol     = 2'($urandom());
    p.beat.coef_index = idx[7:0];
    p.beat.coef_value = val;
    pending_items.push_back(p);
  endtask

  task automatic queue_symbol(input logic [1:0] code, input logic drain);
    pending_t p;
    p.drain           = drain;
    p.beat.cmd        = CMD_SYMBOL;
    p.beat.symbol     = code;
    p.beat.coef_index = 8'($urandom());
    p.beat.coef_value = 16'($urandom());
    pending_items.push_back(p);
  endtask

  function automatic logic signed [15:0] rand_coef();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5)  return COEF_MIN;
    if (pick < 10) return COEF_MAX;
    return 16'($urandom());
  endfunction

  // Sender: drive a new beat at the falling edge only when the last one was
  // taken. Hold the payload steady while stalled; never look at in_stall to
  // decide whether to offer.
  always @(negedge clk) begin : drive_in
    logic     offer;
    pending_t nxt;
    offer = in_valid && !in_took;
    if (rst_n && !offer && pending_items.size() != 0) begin
      nxt = pending_items[0];
      // A drain marker holds the sender until every sample is back.
      if (!(nxt.drain && expected_samples.size() != 0) &&
          ((beats_sent >= SEND_STEADY_LO && beats_sent < SEND_STEADY_HI) ||
           $urandom_range(0, 99) >= IDLE_PCT)) begin
        nxt = pending_items.pop_front();
        in_data <= nxt.beat;
        offer = 1'b1;
      end
    end
    in_valid <= offer;
  end

  // Receiver: random stalls, one clean stretch, and one long hold-off that
  // fills the output register and pushes back on the input.
  always @(negedge clk) begin : drive_out
    if (rst_n) begin
      if (!held_off && samples_seen >= HOLD_AT) begin
        held_off  = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (samples_seen >= RECV_STEADY_LO && samples_seen < RECV_STEADY_HI) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // Sample both handshakes at the rising edge: feed accepted input beats to
  // the predictor, and check each accepted output beat against the oldest
  // expected sample.
  always @(posedge clk) begin : watch
    qpm_out_t want;
    if (!rst_n) begin
      in_took = 1'b0;
    end else begin
      in_took = in_valid && !in_stall;
      if (in_took) begin
        beats_sent++;
        predict_samples(in_data);
      end
      if (out_valid && !out_stall) begin
        samples_seen++;
        if (expected_samples.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected output beat: sample %0d index %0d last %0b", $time,
                   out_data.sample, out_data.sample_index, out_data.last);
        end else begin
          want = expected_samples.pop_front();
          if (out_data.sample !== want.sample) begin
            mismatches++;
            $display("%0t: sample: expected %0d, actual %0d", $time, want.sample,
                     out_data.sample);
          end
          if (out_data.sample_index !== want.sample_index) begin
            mismatches++;
            $display("%0t: sample_index: expected %0d, actual %0d", $time,
                     want.sample_index, out_data.sample_index);
          end
          if (out_data.last !== want.last) begin
            mismatches++;
            $display("%0t: last: expected %0b, actual %0b", $time, want.last, out_data.last);
          end
        end
      end
    end
  end

  // Watchdog: end a hung run.
  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int pick;
    for (int t = 0; t < TAPS; t++) begin
      hist_i[t] = 0;
      hist_q[t] = 0;
    end

    // Load the whole table with the most negative coefficient, so that a
    // full run of one symbol drives the sum to both of its extremes.
    for (int i = 0; i < TABLE_N; i++) queue_coef(i, COEF_MIN, 1'b0);
    // Drop writes past the end of the table; 255 sets every address bit.
    queue_coef(TABLE_N, COEF_MAX, 1'b0);
    queue_coef(255, COEF_MAX, 1'b0);
    // Fill the history with +I: largest magnitude on both signs.
    for (int i = 0; i < TAPS; i++) queue_symbol(SYM_I_POS, 1'b0);
    // Largest positive coefficient at both ends of the table.
    queue_coef(0, COEF_MAX, 1'b0);
    queue_coef(TABLE_N - 1, COEF_MAX, 1'b0);
    queue_symbol(SYM_Q_POS, 1'b0);
    queue_symbol(SYM_Q_NEG, 1'b0);
    queue_symbol(SYM_I_NEG, 1'b0);
    queue_symbol(SYM_I_NEG, 1'b0);

    // Reload the table with random shapes once the directed symbols are out.
    for (int i = 0; i < TABLE_N; i++) queue_coef(i, rand_coef(), i == 0);

    // Mostly symbols, with scattered table updates and stray addresses.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 75)
        queue_symbol(2'($urandom()), n % 90 == 45);
      else if (pick < 95)
        queue_coef($urandom_range(0, TABLE_N - 1), rand_coef(), 1'b0);
      else
        queue_coef($urandom_range(TABLE_N, 255), rand_coef(), 1'b0);
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_valid) @(posedge clk);
    while (expected_samples.size() != 0) @(posedge clk);
    // Let any stray extra beat show up.
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

### filelist.f
hdl/qpm_pkg.sv
hdl/qpm_ctrl.sv
hdl/qpm_datapath.sv
hdl/qpsk_pulse_shaping_modulator.sv
hdl/qpm_checker.sv
verif/qpsk_pulse_shaping_modulator_tb.sv
